/* rtl/fuv_pkg.sv */
package fuv_pkg;

  // Field widths of the two streaming channels and of the max_length register.
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 13;
  localparam int CFG_W    = 12;

  // Configuration port geometry: one 32-bit register at byte address 0.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_MAX_LENGTH = 1'b0;

  // Name length limits. The limit in force is the smaller of the register
  // and LENGTH_LIMIT_MAX; LIMIT_W is wide enough for any value of the latter.
  localparam int LIMIT_W = 16;
  localparam logic [LIMIT_W-1:0] LENGTH_LIMIT_MAX  = 16'd4095;
  localparam logic [CFG_W-1:0]   MAX_LENGTH_RESET  = 12'd255;
  localparam logic [COUNT_W-1:0] COUNT_SAT         = 13'd4096;

  typedef struct packed {
    logic [BYTE_W-1:0] name_byte;
    logic              is_last;
    logic              is_empty;
  } item_t;

  typedef struct packed {
    logic               name_valid;
    logic [COUNT_W-1:0] name_length;
  } result_t;

endpackage

/* rtl/fuv_regs.sv */
module fuv_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fuv_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fuv_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fuv_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [fuv_pkg::CFG_W-1:0]         max_length
);

  logic [fuv_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign reg_idx = paddr[fuv_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= fuv_pkg::MAX_LENGTH_RESET;
    end else if (wr_en && reg_idx == fuv_pkg::REG_MAX_LENGTH) begin
      max_length <= pwdata[fuv_pkg::CFG_W-1:0];
    end
  end

  // Unmapped addresses read as zero.
  always_comb begin
    if (reg_idx == fuv_pkg::REG_MAX_LENGTH) begin
      prdata = {{(fuv_pkg::APB_DATA_W - fuv_pkg::CFG_W){1'b0}}, max_length};
    end else begin
      prdata = '0;
    end
  end

endmodule

/* rtl/fuv_check.sv */
module fuv_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  fuv_pkg::item_t                item,
  input  logic [fuv_pkg::CFG_W-1:0]     max_length,
  output fuv_pkg::result_t              result
);

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CASE_GAP = 8'h20;
  localparam logic [2:0] PREFIX_DEPTH = 3'd4;
  localparam logic [2:0] PREFIX_OVER  = 3'd5;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] SURR_LO     = 21'h00D800;
  localparam logic [20:0] SURR_HI     = 21'h00DFFF;

  // Per-name state, cleared at reset and after every result.
  logic [1:0]                 cont_left, cont_left_next;
  logic [20:0]                cp_acc, cp_acc_next;
  logic [1:0]                 min_class, min_class_next;
  logic                       err_seen, err_seen_next;
  logic [fuv_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]                 prefix_chars [4];
  logic [7:0]                 prefix_chars_next [4];
  logic [2:0]                 prefix_length, prefix_length_next;
  logic                       dot_seen, dot_seen_next;

  logic [7:0]                 b;
  logic [7:0]                 b_upper;
  logic [20:0]                cp_shift;
  logic [20:0]                cp_min;
  logic                       err_final;
  logic                       reserved;
  logic [fuv_pkg::LIMIT_W-1:0] limit;
  logic [fuv_pkg::LIMIT_W-1:0] count_wide;
  logic                       ok;

  assign b       = item.name_byte;
  assign b_upper = (b >= CH_LO_A && b <= CH_LO_Z) ? b - CASE_GAP : b;
  assign cp_shift = {cp_acc[14:0], b[5:0]};

  always_comb begin
    case (min_class)
      2'd0:    cp_min = 21'h000080;
      2'd1:    cp_min = 21'h000800;
      default: cp_min = 21'h010000;
    endcase
  end

  always_comb begin
    cont_left_next     = cont_left;
    cp_acc_next        = cp_acc;
    min_class_next     = min_class;
    err_seen_next      = err_seen;
    prefix_length_next = prefix_length;
    dot_seen_next      = dot_seen;
    for (int i = 0; i < 4; i++) begin
      prefix_chars_next[i] = prefix_chars[i];
    end

    byte_count_next = (byte_count < fuv_pkg::COUNT_SAT) ?
                      byte_count + 13'd1 : byte_count;

    // UTF-8 sequence tracking.
    if (cont_left == 2'd0) begin
      if (!b[7]) begin
        cont_left_next = 2'd0;
      end else if (b[7:5] == 3'b110) begin
        cont_left_next = 2'd1;
        cp_acc_next    = {16'd0, b[4:0]};
        min_class_next = 2'd0;
      end else if (b[7:4] == 4'b1110) begin
        cont_left_next = 2'd2;
        cp_acc_next    = {17'd0, b[3:0]};
        min_class_next = 2'd1;
      end else if (b[7:3] == 5'b11110) begin
        cont_left_next = 2'd3;
        cp_acc_next    = {18'd0, b[2:0]};
        min_class_next = 2'd2;
      end else begin
        err_seen_next = 1'b1;
      end
    end else begin
      if (b[7:6] != 2'b10) begin
        err_seen_next = 1'b1;
      end
      cp_acc_next    = cp_shift;
      cont_left_next = cont_left - 2'd1;
      if (cont_left == 2'd1) begin
        if (cp_shift < cp_min || cp_shift > CP_MAX ||
            (cp_shift >= SURR_LO && cp_shift <= SURR_HI)) begin
          err_seen_next = 1'b1;
        end
      end
    end

    // Characters that are never allowed in a name.
    if (b < 8'h20 || b inside {8'h3C, 8'h3E, 8'h3A, 8'h22, 8'h2F, 8'h5C, 8'h7C,
                               8'h3F, 8'h2A}) begin
      err_seen_next = 1'b1;
    end

    // Upper-cased stem before the first dot, kept for the device-name test.
    if (!dot_seen) begin
      if (b == CH_DOT) begin
        dot_seen_next = 1'b1;
      end else if (prefix_length < PREFIX_DEPTH) begin
        prefix_length_next = prefix_length + 3'd1;
        for (int i = 0; i < 4; i++) begin
          if (prefix_length[1:0] == 2'(i)) begin
            prefix_chars_next[i] = b_upper;
          end
        end
      end else begin
        prefix_length_next = PREFIX_OVER;
      end
    end
  end

  always_comb begin
    err_final = err_seen_next | (cont_left_next != 2'd0) | (b == CH_DOT) | (b == CH_SPACE);

    reserved = 1'b0;
    if (prefix_length_next == 3'd3) begin
      reserved = ({prefix_chars_next[0], prefix_chars_next[1], prefix_chars_next[2]} == "CON") ||
                 ({prefix_chars_next[0], prefix_chars_next[1], prefix_chars_next[2]} == "PRN") ||
                 ({prefix_chars_next[0], prefix_chars_next[1], prefix_chars_next[2]} == "AUX") ||
                 ({prefix_chars_next[0], prefix_chars_next[1], prefix_chars_next[2]} == "NUL");
    end else if (prefix_length_next == PREFIX_DEPTH) begin
      reserved = (({prefix_chars_next[0], prefix_chars_next[1], prefix_chars_next[2]} == "COM") ||
                  ({prefix_chars_next[0], prefix_chars_next[1], prefix_chars_next[2]} == "LPT")) &&
                 prefix_chars_next[3] >= CH_ONE && prefix_chars_next[3] <= CH_NINE;
    end

    limit = ({{(fuv_pkg::LIMIT_W - fuv_pkg::CFG_W){1'b0}}, max_length} >
             fuv_pkg::LENGTH_LIMIT_MAX) ? fuv_pkg::LENGTH_LIMIT_MAX :
            {{(fuv_pkg::LIMIT_W - fuv_pkg::CFG_W){1'b0}}, max_length};
    count_wide = {{(fuv_pkg::LIMIT_W - fuv_pkg::COUNT_W){1'b0}}, byte_count_next};

    ok = !err_final && (byte_count_next != '0) && (count_wide <= limit) && !reserved;

    if (item.is_empty) begin
      result.name_valid  = 1'b0;
      result.name_length = '0;
    end else begin
      result.name_valid  = ok;
      result.name_length = byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && (item.is_last || item.is_empty))) begin
      cont_left     <= '0;
      cp_acc        <= '0;
      min_class     <= '0;
      err_seen      <= 1'b0;
      byte_count    <= '0;
      prefix_length <= '0;
      dot_seen      <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        prefix_chars[i] <= '0;
      end
    end else if (step) begin
      cont_left     <= cont_left_next;
      cp_acc        <= cp_acc_next;
      min_class     <= min_class_next;
      err_seen      <= err_seen_next;
      byte_count    <= byte_count_next;
      prefix_length <= prefix_length_next;
      dot_seen      <= dot_seen_next;
      for (int i = 0; i < 4; i++) begin
        prefix_chars[i] <= prefix_chars_next[i];
      end
    end
  end

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    step && (item.is_last || item.is_empty) |=>
      byte_count == '0 && cont_left == 2'd0 && !err_seen && prefix_length == 3'd0)
    else $error("name state not cleared after a result");

  a_prefix_range: assert property (@(posedge clk) disable iff (rst)
    prefix_length <= PREFIX_OVER)
    else $error("prefix length out of range");

endmodule

/* rtl/filename_utf8_validator_core.sv */
// Channel   Beat                      Handshake                   Direction
// item      name_byte,is_last,is_empty item_valid / item_ready    in
// result    name_valid,name_length    result_valid / result_ready out
// config    max_length (addr 0x0)     psel/penable/pwrite/pready  in (APB-style)
//
// One byte beat is accepted every cycle while the output side keeps up.
// A beat is registered on acceptance and checked in the following cycle by the
// name checker. Its result is loaded into the result register as the last or
// empty beat leaves the input register.
// Reset (rst, synchronous) clears all name state and sets max_length to 255.
// A result waiting on result_ready holds the stage that feeds it only when
// that stage also carries a result; plain bytes keep flowing.
module filename_utf8_validator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  fuv_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output fuv_pkg::result_t                  result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fuv_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fuv_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fuv_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  // Input register: holds the beat being checked this cycle.
  logic             s1_valid;
  fuv_pkg::item_t   s1_item;
  logic             s1_emits;
  logic             s1_go;

  logic [fuv_pkg::CFG_W-1:0] max_length;
  fuv_pkg::result_t          chk_result;

  fuv_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_length (max_length)
  );

  // The checker updates its per-name state on s1_go and presents the result
  // of the beat in s1 combinationally.
  fuv_check u_check (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_go),
    .item       (s1_item),
    .max_length (max_length),
    .result     (chk_result)
  );

  // Only last and empty beats produce a result. Such a beat can leave the
  // input register only when the result register is free or being emptied.
  assign s1_emits   = s1_item.is_last | s1_item.is_empty;
  assign s1_go      = s1_valid && (!s1_emits || !result_valid || result_ready);
  assign item_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
  end

  // Result register: a finished result waits here for result_ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_emits) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emits) begin
      result <= chk_result;
    end
  end

  // A result-bearing beat must not advance over a stalled result.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_emits && result_valid && !result_ready |=> s1_valid)
    else $error("result beat advanced over a stalled result");

  // Back-pressure on the input only ever comes from a full input register.
  a_ready_source: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> s1_valid)
    else $error("item_ready low with an empty input register");

  // An accepted name is never empty and never beyond the hard limit.
  a_valid_length: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.name_valid |->
      result.name_length != '0 &&
      {{(fuv_pkg::LIMIT_W - fuv_pkg::COUNT_W){1'b0}}, result.name_length} <=
        fuv_pkg::LENGTH_LIMIT_MAX)
    else $error("valid name with an impossible length");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

// Testbench for the file name checker core.
//
// Stimulus is a stream of name beats (one byte each, the final byte flagged)
// plus the odd empty-name beat. An initial block fills a queue of pending
// beats phase by phase, and a clocked driver presents them on the item
// channel with random idle bursts. Every beat accepted by the core goes
// through a predictor in this file that tracks the UTF-8 decoder, the
// character rules, the device-name prefix and the length count. A clocked
// monitor pops the oldest expected verdict for each result beat and compares
// it field by field.
//
// The max_length register is only touched while the core is idle: after
// reset and between phases, once every expected verdict has arrived and the
// pipeline has had time to swallow any trailing bytes that produce no result.
module tb;

  typedef logic [7:0] octet_q[$];

  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [fuv_pkg::REG_IDX_W-1:0]  REG_UNMAPPED    = 1'b1;
  localparam logic [fuv_pkg::APB_ADDR_W-1:0] ADDR_MAX_LENGTH =
    {fuv_pkg::REG_MAX_LENGTH, 2'b00};
  localparam logic [fuv_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED   = {REG_UNMAPPED, 2'b00};

  // Code point bounds used by the UTF-8 rules.
  localparam logic [20:0] CP_MAX  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;

  // Characters used to build names: ones that pass every rule, and the ones
  // that are banned outright.
  localparam string SAFE_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_~!#$%&'()+,;=@[]^`{}";
  localparam string BANNED_CHARS = "<>:\"/\\|?*";

  string device_words[6] = '{"con", "prn", "aux", "nul", "com", "lpt"};

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  // Item channel.
  logic            item_valid = 1'b0;
  logic            item_ready;
  fuv_pkg::item_t  item_bus   = '0;

  // Result channel.
  logic             result_valid;
  logic             result_ready = 1'b1;
  fuv_pkg::result_t result_bus;

  // Configuration port.
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [fuv_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [fuv_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [fuv_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  filename_utf8_validator_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_bus),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_bus),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Beats waiting to be driven, and verdicts waiting to come out.
  fuv_pkg::item_t   pending_beats[$];
  fuv_pkg::result_t verdicts[$];
  octet_q           name_buf;

  int mismatches   = 0;
  int idle_pct     = 0;
  int feed_gap     = 0;
  int drain_stall  = 0;
  int quiet_cycles = 0;

  fuv_pkg::result_t due_verdict;

  // Queue helpers: append at the tail.
  task automatic add_byte(input logic [7:0] v);
    name_buf.insert(name_buf.size(), v);
  endtask

  task automatic queue_beat(input fuv_pkg::item_t beat);
    pending_beats.insert(pending_beats.size(), beat);
  endtask

  task automatic owe_verdict(input fuv_pkg::result_t verdict);
    verdicts.insert(verdicts.size(), verdict);
  endtask

  // ---------------------------------------------------------------------
  // Predictor state. It mirrors what the core keeps for the name in flight.
  // ---------------------------------------------------------------------
  logic [fuv_pkg::CFG_W-1:0]   limit_reg;
  logic [1:0]                  cont_left;
  logic [20:0]                 cp_acc;
  logic [1:0]                  min_cls;
  logic                        err_flag;
  logic [fuv_pkg::COUNT_W-1:0] seen_count;
  logic [7:0]                  stem_chars[4];
  logic [2:0]                  stem_len;
  logic                        dot_hit;

  task automatic clear_name();
    cont_left  = '0;
    cp_acc     = '0;
    min_cls    = '0;
    err_flag   = 1'b0;
    seen_count = '0;
    foreach (stem_chars[i]) stem_chars[i] = '0;
    stem_len   = '0;
    dot_hit    = 1'b0;
  endtask

  // Folds one accepted beat into the name state and, on a final or empty
  // beat, queues the verdict the core ought to give.
  task automatic judge_beat(input fuv_pkg::item_t beat);
    logic [7:0]   b;
    logic [20:0]  floor_cp;
    logic [15:0]  lim;
    logic [23:0]  stem3;
    logic         reserved;
    logic         ok;
    b = beat.name_byte;
    if (beat.is_empty) begin
      // An empty beat always fails and throws away any partial name.
      owe_verdict(fuv_pkg::result_t'{name_valid: 1'b0, name_length: '0});
      clear_name();
    end else begin
      if (seen_count < fuv_pkg::COUNT_SAT) seen_count = seen_count + 1'b1;

      if (cont_left == 2'd0) begin
        if (b[7:5] == 3'b110) begin
          cont_left = 2'd1;
          cp_acc    = {16'b0, b[4:0]};
          min_cls   = 2'd0;
        end else if (b[7:4] == 4'b1110) begin
          cont_left = 2'd2;
          cp_acc    = {17'b0, b[3:0]};
          min_cls   = 2'd1;
        end else if (b[7:3] == 5'b11110) begin
          // F5..F7 land here too; the range check at the end catches them.
          cont_left = 2'd3;
          cp_acc    = {18'b0, b[2:0]};
          min_cls   = 2'd2;
        end else if (b[7]) begin
          err_flag = 1'b1;
        end
      end else begin
        // A bad continuation is still shifted in and still counts.
        if (b[7:6] != 2'b10) err_flag = 1'b1;
        cp_acc    = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 1'b1;
        if (cont_left == 2'd0) begin
          floor_cp = (min_cls == 2'd0) ? 21'h80 : (min_cls == 2'd1) ? 21'h800 : 21'h10000;
          if (cp_acc < floor_cp || cp_acc > CP_MAX || (cp_acc >= SURR_LO && cp_acc <= SURR_HI))
            err_flag = 1'b1;
        end
      end

      if (b < 8'h20) err_flag = 1'b1;
      case (b)
        "<", ">", ":", "\"", "/", "\\", "|", "?", "*": err_flag = 1'b1;
        default: ;
      endcase

      if (!dot_hit) begin
        if (b == ".") begin
          dot_hit = 1'b1;
        end else if (stem_len < 3'd4) begin
          stem_chars[stem_len] = (b >= "a" && b <= "z") ? b - 8'h20 : b;
          stem_len = stem_len + 1'b1;
        end else begin
          stem_len = 3'd5;
        end
      end

      if (beat.is_last) begin
        if (cont_left != 2'd0) err_flag = 1'b1;
        if (b == "." || b == " ") err_flag = 1'b1;
        lim = {{(fuv_pkg::LIMIT_W-fuv_pkg::CFG_W){1'b0}}, limit_reg};
        if (lim > fuv_pkg::LENGTH_LIMIT_MAX) lim = fuv_pkg::LENGTH_LIMIT_MAX;
        stem3 = {stem_chars[0], stem_chars[1], stem_chars[2]};
        reserved = 1'b0;
        if (stem_len == 3'd3)
          reserved = stem3 == "CON" || stem3 == "PRN" || stem3 == "AUX" || stem3 == "NUL";
        if (stem_len == 3'd4)
          reserved = (stem3 == "COM" || stem3 == "LPT") &&
                     stem_chars[3] >= "1" && stem_chars[3] <= "9";
        ok = !err_flag && seen_count >= 1 && seen_count <= lim && !reserved;
        owe_verdict(fuv_pkg::result_t'{name_valid: ok, name_length: seen_count});
        clear_name();
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver. A beat stays on the bus until it is taken; only once the slot
  // is free does the driver either idle for a short burst or load the next
  // pending beat. Each accepted beat is handed to the predictor.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item_bus   <= '0;
      feed_gap   = 0;
    end else begin
      if (item_valid && item_ready) judge_beat(item_bus);
      if (!item_valid || item_ready) begin
        if (feed_gap > 0) begin
          feed_gap = feed_gap - 1;
          item_valid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          feed_gap = $urandom_range(0, 3);
          item_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          item_valid <= 1'b1;
          item_bus   <= pending_beats.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor. Stalls the result side in bursts and checks each result beat
  // against the oldest verdict still owed.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b1;
      drain_stall  = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (verdicts.size() == 0) begin
          $display("%0t: result beat with no verdict owed, got valid %0b length %0d",
                   $time, result_bus.name_valid, result_bus.name_length);
          mismatches++;
        end else begin
          due_verdict = verdicts.pop_front();
          if (result_bus.name_valid !== due_verdict.name_valid) begin
            $display("%0t: name_valid expected %0b, got %0b",
                     $time, due_verdict.name_valid, result_bus.name_valid);
            mismatches++;
          end
          if (result_bus.name_length !== due_verdict.name_length) begin
            $display("%0t: name_length expected %0d, got %0d",
                     $time, due_verdict.name_length, result_bus.name_length);
            mismatches++;
          end
        end
      end
      if (drain_stall > 0) begin
        drain_stall = drain_stall - 1;
        result_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        drain_stall = $urandom_range(0, 3);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a long run of cycles with no beat moving anywhere means a hang.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Configuration access. Both tasks finish on a falling edge so that the
  // caller never touches the queues in the same step as the driver.
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [fuv_pkg::APB_ADDR_W-1:0] addr,
                           input logic [fuv_pkg::APB_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    // Writes to anything but max_length are simply dropped by the core.
    if (addr == ADDR_MAX_LENGTH) limit_reg = data[fuv_pkg::CFG_W-1:0];
    @(negedge clk);
  endtask

  task automatic read_back();
    logic [fuv_pkg::APB_DATA_W-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MAX_LENGTH;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {{(fuv_pkg::APB_DATA_W-fuv_pkg::CFG_W){1'b0}}, limit_reg}) begin
      $display("%0t: max_length read expected %0d, got %0d", $time, limit_reg, got);
      mismatches++;
    end
    @(negedge clk);
  endtask

  // Waits until every beat has gone in and every verdict has come out, then
  // gives the pipeline time to swallow trailing bytes with no result.
  task automatic settle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || item_valid || verdicts.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Name builders. Bytes collect in name_buf and are then queued as beats.
  // ---------------------------------------------------------------------
  task automatic emit_name(input bit terminate);
    foreach (name_buf[i])
      queue_beat(fuv_pkg::item_t'{name_byte: name_buf[i],
                                  is_last: terminate && (i == name_buf.size() - 1),
                                  is_empty: 1'b0});
    name_buf.delete();
  endtask

  task automatic emit_empty();
    queue_beat(fuv_pkg::item_t'{name_byte: 8'($urandom), is_last: 1'($urandom),
                                is_empty: 1'b1});
  endtask

  task automatic add_text(input string t);
    for (int i = 0; i < t.len(); i++) add_byte(t[i]);
  endtask

  task automatic add_cont();
    add_byte(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  // A multi-byte character of two to four bytes, well-formed except that the three-byte kind may encode a surrogate.
  task automatic add_code_point();
    logic [20:0] cp;
    case ($urandom_range(0, 2))
      0: begin
        cp = 21'($urandom_range(21'h80, 21'h7FF));
        add_byte({3'b110, cp[10:6]});
      end
      1: begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
      end
      default: begin
        cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
      end
    endcase
    add_byte({2'b10, cp[5:0]});
  endtask

  // One malformed sequence of a randomly chosen kind.
  task automatic add_broken();
    case ($urandom_range(0, 9))
      0: add_cont();
      1: begin
        add_byte(8'($urandom_range(8'hC0, 8'hC1)));
        add_cont();
      end
      2: begin
        add_byte(8'hE0);
        add_byte(8'($urandom_range(8'h80, 8'h9F)));
        add_cont();
      end
      3: begin
        add_byte(8'hF0);
        add_byte(8'($urandom_range(8'h80, 8'h8F)));
        add_cont();
        add_cont();
      end
      4: begin
        add_byte(8'hED);
        add_byte(8'($urandom_range(8'hA0, 8'hBF)));
        add_cont();
      end
      5: begin
        add_byte(8'hF4);
        add_byte(8'($urandom_range(8'h90, 8'hBF)));
        add_cont();
        add_cont();
      end
      6: begin
        add_byte(8'($urandom_range(8'hF5, 8'hF7)));
        repeat (3) add_cont();
      end
      7: add_byte(8'($urandom_range(8'hF8, 8'hFF)));
      8: begin
        // Sequence cut short by one or more continuation bytes.
        case ($urandom_range(0, 2))
          0: add_byte(8'($urandom_range(8'hC2, 8'hDF)));
          1: begin
            add_byte(8'hE1);
            repeat ($urandom_range(0, 1)) add_cont();
          end
          default: begin
            add_byte(8'hF1);
            repeat ($urandom_range(0, 2)) add_cont();
          end
        endcase
      end
      default: begin
        add_byte(8'($urandom_range(8'hC2, 8'hDF)));
        add_byte(8'($urandom_range(0, 1) ? $urandom_range(8'h00, 8'h7F)
                                         : $urandom_range(8'hC0, 8'hFF)));
      end
    endcase
  endtask

  task automatic add_char();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)      add_byte(SAFE_CHARS[$urandom_range(0, SAFE_CHARS.len() - 1)]);
    else if (pick < 68) add_byte(".");
    else if (pick < 73) add_byte(" ");
    else if (pick < 88) add_code_point();
    else if (pick < 93) add_byte(BANNED_CHARS[$urandom_range(0, BANNED_CHARS.len() - 1)]);
    else if (pick < 96) add_byte(8'($urandom_range(0, 1) ? $urandom_range(8'h00, 8'h1F)
                                                         : 8'h7F));
    else                add_broken();
  endtask

  // Queues one random name: mostly plausible names with random content,
  // a share of device names in mixed case, and some noise and broken ones.
  task automatic compose_name();
    int unsigned kind;
    int unsigned pick;
    string word;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      repeat (($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 10)) add_char();
      emit_name(1'b1);
    end else if (kind < 70) begin
      word = device_words[$urandom_range(0, 5)];
      for (int i = 0; i < word.len(); i++) begin
        c = word[i];
        add_byte($urandom_range(0, 1) ? c - 8'h20 : c);
      end
      if (word == "com" || word == "lpt") begin
        pick = $urandom_range(0, 11);
        if (pick < 10)       add_byte(8'("0" + pick));
        else if (pick == 10) add_byte("x");
      end
      case ($urandom_range(0, 3))
        0: ;
        1: add_text(".txt");
        2: add_char();
        default: add_byte(".");
      endcase
      emit_name(1'b1);
    end else if (kind < 78) begin
      add_char();
      add_broken();
      repeat ($urandom_range(0, 2)) add_char();
      emit_name(1'b1);
    end else if (kind < 88) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      emit_name(1'b1);
    end else if (kind < 94) begin
      emit_empty();
    end else begin
      // A name abandoned part way by an empty beat.
      repeat ($urandom_range(1, 5)) add_char();
      emit_name(1'b0);
      emit_empty();
    end
  endtask

  task automatic random_phase(input int budget);
    while (pending_beats.size() < budget) compose_name();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    logic [fuv_pkg::APB_DATA_W-1:0] data;
    clear_name();
    limit_reg = fuv_pkg::MAX_LENGTH_RESET;
    idle_pct  = 20;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The register must come out of reset at its default.
    read_back();

    // Directed beats at the reset limit.
    queue_beat(fuv_pkg::item_t'{name_byte: 8'hFF, is_last: 1'b1, is_empty: 1'b1});
    add_text("a");
    emit_name(1'b0);
    queue_beat(fuv_pkg::item_t'{name_byte: 8'h00, is_last: 1'b0, is_empty: 1'b1});
    add_text("x");
    emit_name(1'b1);
    add_text("Com7");
    emit_name(1'b1);
    add_text("a.");
    emit_name(1'b1);
    name_buf = '{8'hFF};
    emit_name(1'b1);
    name_buf = '{8'h00};
    emit_name(1'b1);
    name_buf = '{8'hC0, 8'hAF};
    emit_name(1'b1);
    name_buf = '{8'hED, 8'hA0, 8'h80};
    emit_name(1'b1);
    name_buf = '{8'hF5, 8'h80, 8'h80, 8'h80};
    emit_name(1'b1);
    name_buf = '{8'hE2, 8'h82};
    emit_name(1'b1);
    name_buf = '{8'hC3, 8'h41};
    emit_name(1'b1);
    settle();

    // Widest limit.
    idle_pct = $urandom_range(5, 30);
    write_reg(ADDR_UNMAPPED, $urandom);
    read_back();
    write_reg(ADDR_MAX_LENGTH, 32'h0000_0FFF);
    random_phase(100);
    settle();

    // Zero limit, written with the unused upper bits set.
    idle_pct = $urandom_range(10, 40);
    write_reg(ADDR_MAX_LENGTH, 32'hFFFF_F000);
    read_back();
    random_phase(120);
    settle();

    // Single-byte limit.
    idle_pct = $urandom_range(10, 40);
    data = $urandom;
    data[fuv_pkg::CFG_W-1:0] = 12'd1;
    write_reg(ADDR_MAX_LENGTH, data);
    random_phase(120);
    settle();

    // A small limit that random name lengths straddle.
    idle_pct = $urandom_range(0, 40);
    data = $urandom;
    data[fuv_pkg::CFG_W-1:0] = 12'($urandom_range(2, 16));
    write_reg(ADDR_MAX_LENGTH, data);
    read_back();
    random_phase(120);
    settle();

    // Back to the default limit, flat out on both sides.
    idle_pct = 0;
    write_reg(ADDR_MAX_LENGTH,
              {{(fuv_pkg::APB_DATA_W-fuv_pkg::CFG_W){1'b0}}, fuv_pkg::MAX_LENGTH_RESET});
    random_phase(140);
    settle();

    if (mismatches == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
